>>> hw/rtl/first_fit_slot_allocator_unit_assert.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define FFSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define FFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`else

`define FFSA_ASSERT(label, clk, rst_n, prop, msg)
`define FFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/ffsa_pkg.sv
`timescale 1ns / 1ps

package ffsa_pkg;

  localparam int unsigned MemWords    = 128;
  localparam int unsigned HandleCount = 32;

  localparam int unsigned SlotIdxW   = $clog2(MemWords);
  localparam int unsigned AddrW      = $clog2(MemWords + 1);
  localparam int unsigned HandleIdxW = $clog2(HandleCount);

  localparam int unsigned OpW     = 2;
  localparam int unsigned HandleW = 5;
  localparam int unsigned SizeW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutAddrW = 8;

  localparam logic [OpW-1:0] OpAlloc   = 2'd0;
  localparam logic [OpW-1:0] OpLookup  = 2'd1;
  localparam logic [OpW-1:0] OpRelease = 2'd2;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StTaken  = 2'd1;
  localparam logic [StatusW-1:0] StNoRoom = 2'd2;
  localparam logic [StatusW-1:0] StAbsent = 2'd3;

  // One write into the slot occupancy map.
  typedef struct packed {
    logic                en;
    logic [SlotIdxW-1:0] idx;
    logic                val;
  } slot_wr_t;

  // One update of the handle table: set installs an entry, clr drops it.
  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic [HandleIdxW-1:0] idx;
    logic [AddrW-1:0]      base;
    logic [AddrW-1:0]      limit;
  } tbl_wr_t;

endpackage

>>> hw/rtl/ffsa_slot_map.sv
`timescale 1ns / 1ps

// Occupancy bit per data word, cleared by reset, one registered read port and
// one write port. The read data for an index shows up in the cycle after the
// index is presented.
module ffsa_slot_map
  import ffsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SlotIdxW-1:0] rd_idx_i,
  output logic                used_o,
  input  slot_wr_t            wr_i
);

  logic [MemWords-1:0] used_q;
  logic                used_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      used_rd_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        used_q[wr_i.idx] <= wr_i.val;
      end
      used_rd_q <= used_q[rd_idx_i];
    end
  end

  assign used_o = used_rd_q;

endmodule

>>> hw/rtl/ffsa_handle_table.sv
`timescale 1ns / 1ps

// Per-handle valid flags and a memory of run bounds with a registered read.
module ffsa_handle_table
  import ffsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [HandleIdxW-1:0] rd_idx_i,
  output logic                  rd_valid_o,
  output logic [AddrW-1:0]      rd_base_o,
  output logic [AddrW-1:0]      rd_limit_o,
  input  tbl_wr_t               wr_i
);

  logic [HandleCount-1:0] valid_q;
  logic [AddrW-1:0]       base_mem [HandleCount];
  logic [AddrW-1:0]       limit_mem [HandleCount];
  logic                   rd_valid_q;
  logic [AddrW-1:0]       rd_base_q;
  logic [AddrW-1:0]       rd_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.set) begin
        valid_q[wr_i.idx] <= 1'b1;
      end else if (wr_i.clr) begin
        valid_q[wr_i.idx] <= 1'b0;
      end
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      base_mem[wr_i.idx]  <= wr_i.base;
      limit_mem[wr_i.idx] <= wr_i.limit;
    end
    rd_base_q  <= base_mem[rd_idx_i];
    rd_limit_q <= limit_mem[rd_idx_i];
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_base_o  = rd_base_q;
  assign rd_limit_o = rd_limit_q;

endmodule

>>> hw/rtl/first_fit_slot_allocator_unit.sv
// First-fit allocator for contiguous runs of a 128-word data memory, tracked
// under 32 numeric handles. Each transaction on the input channel (allocate,
// look up, release) gives exactly one transaction on the output channel with a
// status and the run bounds (zero bounds on any error). The block works on one
// transaction at a time: in_ready_o is high only while the sequencer is idle.
// A lookup, an allocate refused before the search (taken handle, zero or
// oversized request) and an unknown operation go from the table read straight
// to the result. A release first frees the words of the run one per cycle. An
// allocate first runs the first-fit search, which walks the occupancy map one
// word per cycle from address 0 until a long enough free run ends (at most 128
// words), and then marks the claimed words one per cycle. An allocate that
// finds no room scans all 128 words. The search and the marking pass run one
// after the other under the same sequencer. The next transaction may be
// accepted while the previous result still waits for out_ready_i; the
// sequencer only stalls before loading a new result.
`timescale 1ns / 1ps

`include "first_fit_slot_allocator_unit_assert.svh"

module first_fit_slot_allocator_unit
  import ffsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OpW-1:0]      operation_i,
  input  logic [HandleW-1:0]  handle_i,
  input  logic [SizeW-1:0]    run_size_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [OutAddrW-1:0] base_address_o,
  output logic [OutAddrW-1:0] limit_address_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // Transaction being worked on.
  logic [OpW-1:0]      op_q;
  logic [HandleW-1:0]  handle_q;
  logic [SizeW-1:0]    size_q;

  // Address counters for the search and the mark/free pass.
  logic [SlotIdxW-1:0] scan_q, scan_d;
  logic [AddrW-1:0]    run_q, run_d;
  logic [AddrW-1:0]    ptr_q, ptr_d;
  logic [AddrW-1:0]    lim_q, lim_d;
  logic                fill_set_q, fill_set_d;

  // Result waiting to be moved into the output register.
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic [AddrW-1:0]    res_base_q, res_base_d;
  logic [AddrW-1:0]    res_limit_q, res_limit_d;

  logic [StatusW-1:0]  out_status_q, out_status_d;
  logic [AddrW-1:0]    out_base_q, out_base_d;
  logic [AddrW-1:0]    out_limit_q, out_limit_d;

  logic                accept;
  logic                handle_in_range;
  logic                slot_used;
  logic                tbl_valid;
  logic [AddrW-1:0]    tbl_base;
  logic [AddrW-1:0]    tbl_limit;
  logic [AddrW-1:0]    run_inc;
  logic [AddrW-1:0]    run_start;
  logic [AddrW-1:0]    size_addr;
  slot_wr_t            slot_wr;
  tbl_wr_t             tbl_wr;

  // The map read is registered, so it is addressed with the next search
  // address; the bit for scan_q is then ready in the cycle scan_q holds it.
  ffsa_slot_map u_slot_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (scan_d),
    .used_o   (slot_used),
    .wr_i     (slot_wr)
  );

  // The table is read at the incoming handle so that the entry is ready in
  // the cycle right after the transaction is accepted.
  ffsa_handle_table u_handle_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (HandleIdxW'(handle_i)),
    .rd_valid_o (tbl_valid),
    .rd_base_o  (tbl_base),
    .rd_limit_o (tbl_limit),
    .wr_i       (tbl_wr)
  );

  assign in_ready_o      = (state_q == S_IDLE);
  assign accept          = in_valid_i && in_ready_o;
  assign handle_in_range = (32'(handle_q) < HandleCount);
  assign size_addr       = AddrW'(size_q);
  assign run_inc         = run_q + AddrW'(1);
  // Start of the free run that ends at the current search address.
  assign run_start       = AddrW'(scan_q) - run_q;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    scan_d       = scan_q;
    run_d        = run_q;
    ptr_d        = ptr_q;
    lim_d        = lim_q;
    fill_set_d   = fill_set_q;
    res_status_d = res_status_q;
    res_base_d   = res_base_q;
    res_limit_d  = res_limit_q;
    out_status_d = out_status_q;
    out_base_d   = out_base_q;
    out_limit_d  = out_limit_q;
    slot_wr      = '0;
    tbl_wr       = '0;
    tbl_wr.idx   = HandleIdxW'(handle_q);
    tbl_wr.base  = res_base_q;
    tbl_wr.limit = res_limit_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end

      S_READ: begin
        // Errors answer with zero bounds unless overwritten below.
        res_base_d  = '0;
        res_limit_d = '0;
        state_d     = S_DONE;
        case (op_q)
          OpAlloc: begin
            if (!handle_in_range || (size_q == '0)) begin
              res_status_d = StNoRoom;
            end else if (tbl_valid) begin
              res_status_d = StTaken;
            end else if (32'(size_q) > MemWords) begin
              res_status_d = StNoRoom;
            end else begin
              scan_d  = '0;
              run_d   = '0;
              state_d = S_SCAN;
            end
          end
          OpLookup, OpRelease: begin
            if (!handle_in_range || !tbl_valid) begin
              res_status_d = StAbsent;
            end else begin
              res_status_d = StOk;
              res_base_d   = tbl_base;
              res_limit_d  = tbl_limit;
              if (op_q == OpRelease) begin
                ptr_d      = tbl_base;
                lim_d      = tbl_limit;
                fill_set_d = 1'b0;
                state_d    = S_FILL;
              end
            end
          end
          default: begin
            res_status_d = StAbsent;
          end
        endcase
      end

      S_SCAN: begin
        if (!slot_used && (run_inc >= size_addr)) begin
          // Found the lowest-addressed run that is long enough.
          res_status_d = StOk;
          res_base_d   = run_start;
          res_limit_d  = run_start + size_addr;
          ptr_d        = run_start;
          lim_d        = run_start + size_addr;
          fill_set_d   = 1'b1;
          state_d      = S_FILL;
        end else if (scan_q == SlotIdxW'(MemWords - 1)) begin
          res_status_d = StNoRoom;
          state_d      = S_DONE;
        end else begin
          run_d  = slot_used ? '0 : run_inc;
          scan_d = scan_q + SlotIdxW'(1);
        end
      end

      S_FILL: begin
        if (ptr_q < lim_q) begin
          slot_wr.en  = 1'b1;
          slot_wr.idx = ptr_q[SlotIdxW-1:0];
          slot_wr.val = fill_set_q;
          ptr_d       = ptr_q + AddrW'(1);
        end else begin
          tbl_wr.set = fill_set_q;
          tbl_wr.clr = !fill_set_q;
          state_d    = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_base_d   = res_base_q;
          out_limit_d  = res_limit_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      handle_q <= handle_i;
      size_q   <= run_size_i;
    end
    scan_q       <= scan_d;
    run_q        <= run_d;
    ptr_q        <= ptr_d;
    lim_q        <= lim_d;
    fill_set_q   <= fill_set_d;
    res_status_q <= res_status_d;
    res_base_q   <= res_base_d;
    res_limit_q  <= res_limit_d;
    out_status_q <= out_status_d;
    out_base_q   <= out_base_d;
    out_limit_q  <= out_limit_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign base_address_o  = OutAddrW'(out_base_q);
  assign limit_address_o = OutAddrW'(out_limit_q);

  // A newly accepted transaction always goes to the table read first.
  `FFSA_ASSERT(a_accept_to_read, clk_i, rst_ni, accept |=> (state_q == S_READ),
    "accepted transaction did not enter the table read")
  // The occupancy map changes only during the mark/free pass.
  `FFSA_ASSERT_IMPL(a_slot_wr_in_fill, clk_i, rst_ni, slot_wr.en, (state_q == S_FILL),
    "slot map written outside the fill pass")
  // A table entry is installed only at the end of a successful allocation.
  `FFSA_ASSERT_IMPL(a_tbl_set_alloc, clk_i, rst_ni, tbl_wr.set,
    (state_q == S_FILL) && fill_set_q && (op_q == OpAlloc) && (res_status_q == StOk),
    "handle entry installed outside a successful allocation")
  // Every error result carries zero bounds.
  `FFSA_ASSERT_IMPL(a_err_zero_bounds, clk_i, rst_ni, out_valid_o && (status_o != StOk),
    (base_address_o == '0) && (limit_address_o == '0),
    "error result with nonzero bounds")

endmodule

>>> tb/sv/tb_first_fit_slot_allocator_unit.sv
`timescale 1ns / 1ps

module tb_first_fit_slot_allocator_unit;
  import ffsa_pkg::*;

  // The package names the three operations the block knows. Code 3 is
  // unused, and the block has to answer it as "not allocated".
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  // Longest stretch without any transaction before the run is called hung.
  // The longest allocate together with the long receiver hold-off below stays
  // well under this, so it leaves a wide margin.
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 300;
  localparam int unsigned RandomItems  = 1075;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [OutAddrW-1:0] base;
    logic [OutAddrW-1:0] limit;
  } reply_t;

  // The scoreboard keeps its own copy of the occupancy map and the handle
  // table. Every accepted request is applied to that copy in order, and the
  // reply it implies is queued. Replies from the block are then matched
  // against the queue head.
  class slot_table_model;
    bit                slot_busy[MemWords];
    bit                in_use[HandleCount];
    bit [OutAddrW-1:0] run_base[HandleCount];
    bit [OutAddrW-1:0] run_limit[HandleCount];
    reply_t            pending_replies[$];
    int                errors;

    function new();
      errors = 0;
      foreach (slot_busy[a]) slot_busy[a] = 1'b0;
      foreach (in_use[h]) begin
        in_use[h]    = 1'b0;
        run_base[h]  = '0;
        run_limit[h] = '0;
      end
    endfunction

    // Applies one request to the table and returns the reply it yields.
    function reply_t apply_request(logic [OpW-1:0] op, logic [HandleW-1:0] h,
                                   logic [SizeW-1:0] size);
      reply_t r;
      int     run;
      int     first;
      bit     found;
      r     = '{status: StAbsent, base: '0, limit: '0};
      run   = 0;
      first = 0;
      found = 1'b0;
      case (op)
        OpAlloc: begin
          if (size == 0) begin
            r.status = StNoRoom;
          end else if (in_use[h]) begin
            r.status = StTaken;
          end else begin
            // First fit: the run ends at the first word where enough
            // consecutive free words have been seen.
            for (int a = 0; a < MemWords && !found; a++) begin
              if (!slot_busy[a]) begin
                run++;
                if (run >= size) begin
                  first = a + 1 - run;
                  found = 1'b1;
                end
              end else begin
                run = 0;
              end
            end
            if (found) begin
              for (int a = first; a < first + size; a++) slot_busy[a] = 1'b1;
              in_use[h]    = 1'b1;
              run_base[h]  = OutAddrW'(first);
              run_limit[h] = OutAddrW'(first + size);
              r = '{status: StOk, base: run_base[h], limit: run_limit[h]};
            end else begin
              r.status = StNoRoom;
            end
          end
        end
        OpLookup, OpRelease: begin
          if (in_use[h]) begin
            r = '{status: StOk, base: run_base[h], limit: run_limit[h]};
            if (op == OpRelease) begin
              for (int a = run_base[h]; a < run_limit[h]; a++) slot_busy[a] = 1'b0;
              in_use[h] = 1'b0;
            end
          end
        end
        default: r.status = StAbsent;
      endcase
      return r;
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [HandleW-1:0] h,
                               logic [SizeW-1:0] size);
      pending_replies.push_back(apply_request(op, h, size));
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d base %0d limit %0d",
               got.status, got.base, got.limit);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.base !== want.base) begin
        $error("base_address: expected %0d, got %0d", want.base, got.base);
        errors++;
      end
      if (got.limit !== want.limit) begin
        $error("limit_address: expected %0d, got %0d", want.limit, got.limit);
        errors++;
      end
    endfunction

    // Returns some handle that currently owns a run, or -1 if none does.
    function int pick_live_handle();
      int start;
      int idx;
      start = $urandom_range(0, HandleCount - 1);
      for (int k = 0; k < HandleCount; k++) begin
        idx = (start + k) % HandleCount;
        if (in_use[idx]) return idx;
      end
      return -1;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OpW-1:0]      operation_i = OpAlloc;
  logic [HandleW-1:0]  handle_i = '0;
  logic [SizeW-1:0]    run_size_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [OutAddrW-1:0] base_address_o;
  logic [OutAddrW-1:0] limit_address_o;

  slot_table_model model;

  // When set, both sides drop their random gaps so that back-to-back
  // transactions are exercised as well.
  bit no_idle = 1'b0;
  int replies_taken = 0;
  int idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  first_fit_slot_allocator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .handle_i       (handle_i),
    .run_size_i     (run_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .base_address_o (base_address_o),
    .limit_address_o(limit_address_o)
  );

  // Monitor. Inputs change on the falling edge only, so at the rising edge
  // both handshakes are seen with stable values. A request is applied to the
  // model before a reply in the same cycle is checked; since a reply never
  // appears in the cycle its own request is accepted, that order is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        model.note_request(operation_i, handle_i, run_size_i);
      end
      if (out_valid_o && out_ready_i) begin
        model.check_reply('{status: status_o, base: base_address_o,
                            limit: limit_address_o});
      end
    end
  end

  // Watchdog. It counts cycles in which neither channel completes a
  // transaction and gives up once the count passes the limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("first_fit_slot_allocator_unit: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one request and returns at the falling edge after it has been
  // accepted. It must be entered at a falling edge. With a gap of zero, valid
  // simply stays high and only the payload changes.
  task automatic send_item(logic [OpW-1:0] op, logic [HandleW-1:0] h,
                           logic [SizeW-1:0] size);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    handle_i    <= h;
    run_size_i  <= size;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Random request. Lookups and releases mostly aim at handles that own a
  // run so that the table really churns; the rest pick a handle at random. Sizes
  // are mostly small to keep scans short and the memory fragmented, with a
  // few full-memory, zero and oversized requests mixed in.
  task automatic random_item();
    int                 roll;
    int                 live;
    logic [OpW-1:0]     op;
    logic [HandleW-1:0] h;
    logic [SizeW-1:0]   size;
    roll = $urandom_range(0, 99);
    if (roll < 45)      op = OpAlloc;
    else if (roll < 72) op = OpRelease;
    else if (roll < 96) op = OpLookup;
    else                op = OpUnused;
    h = HandleW'($urandom_range(0, HandleCount - 1));
    if (op == OpRelease || op == OpLookup) begin
      live = model.pick_live_handle();
      if (live >= 0 && $urandom_range(0, 9) < 9) h = HandleW'(live);
    end
    roll = $urandom_range(0, 99);
    if (roll < 68)      size = SizeW'($urandom_range(1, 8));
    else if (roll < 88) size = SizeW'($urandom_range(9, 40));
    else if (roll < 96) size = SizeW'($urandom_range(41, MemWords));
    else if (roll < 98) size = '0;
    else                size = SizeW'($urandom_range(MemWords + 1, 255));
    send_item(op, h, size);
  endtask

  // Receiver. Before each reply it waits a random number of cycles. Once,
  // after a few dozen replies, it holds ready low for a long stretch while
  // the sender keeps offering requests, so the block ends up holding a
  // finished reply and refusing new work.
  initial begin
    int  stall;
    bit  hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (!hold_done && replies_taken >= 60) begin
        stall     = HoldCycles;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      replies_taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    model = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Error paths on an empty table: a handle that was never allocated, the
    // unused operation code, a zero size and sizes beyond the memory.
    send_item(OpLookup, 5'd5, 8'd0);
    send_item(OpRelease, 5'd5, 8'd7);
    send_item(OpUnused, 5'd0, 8'd1);
    send_item(OpAlloc, 5'd0, 8'd0);
    send_item(OpAlloc, 5'd1, 8'd255);
    send_item(OpAlloc, 5'd2, 8'd129);

    // A run covering the whole memory, then a full-memory refusal, a
    // repeated allocate on a live handle, lookup, release and double release.
    send_item(OpAlloc, 5'd31, 8'd128);
    send_item(OpAlloc, 5'd3, 8'd1);
    send_item(OpAlloc, 5'd31, 8'd1);
    send_item(OpLookup, 5'd31, 8'd0);
    send_item(OpRelease, 5'd31, 8'd0);
    send_item(OpRelease, 5'd31, 8'd0);

    // Fragmentation: open a hole in the middle, check that a large request
    // skips it and that small ones fill it from its low end, then fill the
    // tail exactly so that a single word no longer fits.
    send_item(OpAlloc, 5'd0, 8'd10);
    send_item(OpAlloc, 5'd1, 8'd10);
    send_item(OpAlloc, 5'd2, 8'd10);
    send_item(OpRelease, 5'd1, 8'd0);
    send_item(OpAlloc, 5'd3, 8'd20);
    send_item(OpAlloc, 5'd4, 8'd5);
    send_item(OpAlloc, 5'd5, 8'd5);
    send_item(OpAlloc, 5'd6, 8'd78);
    send_item(OpAlloc, 5'd7, 8'd1);
    send_item(OpLookup, 5'd4, 8'd0);
    send_item(OpRelease, 5'd6, 8'd0);
    send_item(OpLookup, 5'd0, 8'd0);

    // Random traffic, with a back-to-back stretch in each full block of 250.
    for (int n = 0; n < RandomItems; n++) begin
      no_idle = (n % 250) >= 200;
      random_item();
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    // Wait for every expected reply, then watch a while longer so that a
    // stray extra reply would still be caught.
    while (model.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (model.errors == 0) begin
      $display("first_fit_slot_allocator_unit: match");
    end else begin
      $display("first_fit_slot_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
